>>> rtl/core/stl_pkg.sv
// Shared types, codes and character classes for the source text lexer.
// Depends on nothing; every other lexer file imports it.
`timescale 1ns / 1ps

package stl_pkg;

  // Fixed widths of the result fields on the output word
  localparam int TYPE_W  = 5;
  localparam int LINE_W  = 16;
  localparam int COL_W   = 16;
  localparam int START_W = 24;
  localparam int LEN_W   = 16;
  localparam int BYTE_W  = 8;
  localparam int KW_W    = 48;

  // Packed width of the output tdata fields and its byte-rounded size
  localparam int RES_DATA_W = TYPE_W + LINE_W + COL_W + START_W + LEN_W + BYTE_W;
  localparam int OUT_DATA_W = ((RES_DATA_W + 7) / 8) * 8;

  // Keyword spellings, last byte lowest
  localparam logic [KW_W-1:0] KW_VAR    = 48'h0000_0076_6172;
  localparam logic [KW_W-1:0] KW_PRINT  = 48'h0070_7269_6E74;
  localparam logic [KW_W-1:0] KW_IF     = 48'h0000_0000_6966;
  localparam logic [KW_W-1:0] KW_ELSE   = 48'h0000_656C_7365;
  localparam logic [KW_W-1:0] KW_RETURN = 48'h7265_7475_726E;

  typedef enum logic [2:0] {
    MODE_IDLE   = 3'd0,
    MODE_IDENT  = 3'd1,
    MODE_NUMBER = 3'd2,
    MODE_STRING = 3'd3,
    MODE_PEND   = 3'd4
  } lex_mode_e;

  typedef enum logic [1:0] {
    RK_TOKEN   = 2'd0,
    RK_ILLEGAL = 2'd1,
    RK_UNTERM  = 2'd2
  } res_kind_e;

  typedef enum logic [TYPE_W-1:0] {
    TT_VAR     = 5'd0,
    TT_PRINT   = 5'd1,
    TT_IF      = 5'd2,
    TT_ELSE    = 5'd3,
    TT_RETURN  = 5'd4,
    TT_IDENT   = 5'd5,
    TT_NUMBER  = 5'd6,
    TT_STRING  = 5'd7,
    TT_OP      = 5'd8,
    TT_COMPARE = 5'd9,
    TT_ASSIGN  = 5'd10,
    TT_LPAREN  = 5'd11,
    TT_RPAREN  = 5'd12,
    TT_LBRACE  = 5'd13,
    TT_RBRACE  = 5'd14,
    TT_SEMI    = 5'd15,
    TT_END     = 5'd16
  } tok_type_e;

  // One result word
  typedef struct packed {
    res_kind_e           kind;
    tok_type_e           ttype;
    logic [LINE_W-1:0]   line;
    logic [COL_W-1:0]    col;
    logic [START_W-1:0]  start;
    logic [LEN_W-1:0]    len;
    logic [BYTE_W-1:0]   bad;
  } res_t;

  // Results caused by one accepted input word, in order
  typedef struct packed {
    res_t        r0;
    res_t        r1;
    logic [1:0]  count;
  } lex_out_t;

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_word(input logic [7:0] c);
    return is_alpha(c) || is_digit(c) || (c == "_");
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == " ") || ((c >= 8'd9) && (c <= 8'd13));
  endfunction

endpackage

>>> rtl/core/stl_core.sv
// Lexer state and per-byte decision logic: turns one source byte into up to
// two results. Depends on stl_pkg.
`timescale 1ns / 1ps

module stl_core #(
  parameter int OFFSET_WIDTH = 24,
  parameter int COUNT_WIDTH  = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [7:0]        char_i,
  input  logic              end_i,
  output stl_pkg::lex_out_t out_o
);
  import stl_pkg::*;

  localparam int WW = (OFFSET_WIDTH > COUNT_WIDTH) ? OFFSET_WIDTH : COUNT_WIDTH;
  localparam logic [OFFSET_WIDTH-1:0] OFF_MAX = '1;
  localparam logic [COUNT_WIDTH-1:0]  CNT_MAX = '1;

  lex_mode_e                 mode_q, mode_d;
  logic [7:0]                pend_q, pend_d;
  logic [COUNT_WIDTH-1:0]    line_q, line_d;
  logic [OFFSET_WIDTH-1:0]   line_start_q, line_start_d;
  logic [OFFSET_WIDTH-1:0]   off_q, off_d;
  logic [OFFSET_WIDTH-1:0]   tok_start_q, tok_start_d;
  logic [COUNT_WIDTH-1:0]    tok_line_q, tok_line_d;
  logic [KW_W-1:0]           kw_q, kw_d;

  function automatic logic [OFFSET_WIDTH-1:0] off_inc(input logic [OFFSET_WIDTH-1:0] v);
    return (v == OFF_MAX) ? v : v + OFFSET_WIDTH'(1);
  endfunction

  function automatic logic [OFFSET_WIDTH-1:0] diff(input logic [OFFSET_WIDTH-1:0] a,
                                                   input logic [OFFSET_WIDTH-1:0] b);
    return (a > b) ? a - b : '0;
  endfunction

  function automatic logic [COUNT_WIDTH-1:0] cnt_sat(input logic [OFFSET_WIDTH-1:0] v);
    logic [WW-1:0] w;
    w = WW'(v);
    if (w > WW'(CNT_MAX)) return CNT_MAX;
    return COUNT_WIDTH'(w);
  endfunction

  function automatic res_t mk_res(input res_kind_e kind, input tok_type_e ttype,
                                  input logic [COUNT_WIDTH-1:0] line,
                                  input logic [COUNT_WIDTH-1:0] col,
                                  input logic [OFFSET_WIDTH-1:0] start,
                                  input logic [COUNT_WIDTH-1:0] len,
                                  input logic [7:0] bad);
    res_t r;
    r.kind  = kind;
    r.ttype = ttype;
    r.line  = LINE_W'(line);
    r.col   = COL_W'(col);
    r.start = START_W'(start);
    r.len   = LEN_W'(len);
    r.bad   = bad;
    return r;
  endfunction

  logic                     eos;
  logic [OFFSET_WIDTH-1:0]  len_cur;
  logic [COUNT_WIDTH-1:0]   col_tok, col_cur;
  tok_type_e                word_type;
  logic                     flush_v, idle_v, take_idle;
  res_t                     flush_r, idle_r;
  lex_mode_e                idle_mode;
  logic                     a_v, b_v;
  res_t                     a_r, b_r;

  assign eos     = end_i || (char_i == 8'h00);
  assign len_cur = diff(off_q, tok_start_q);
  assign col_tok = cnt_sat(diff(tok_start_q, line_start_q));
  assign col_cur = cnt_sat(diff(off_q, line_start_q));

  // Pick keyword or identifier from the last six bytes and the length
  always_comb begin
    priority if (len_cur == OFFSET_WIDTH'(3) && kw_q == KW_VAR) word_type = TT_VAR;
    else if (len_cur == OFFSET_WIDTH'(5) && kw_q == KW_PRINT) word_type = TT_PRINT;
    else if (len_cur == OFFSET_WIDTH'(2) && kw_q == KW_IF) word_type = TT_IF;
    else if (len_cur == OFFSET_WIDTH'(4) && kw_q == KW_ELSE) word_type = TT_ELSE;
    else if (len_cur == OFFSET_WIDTH'(6) && kw_q == KW_RETURN) word_type = TT_RETURN;
    else word_type = TT_IDENT;
  end

  // Token left open by the previous bytes
  always_comb begin
    flush_v = 1'b0;
    flush_r = mk_res(RK_TOKEN, TT_IDENT, tok_line_q, col_tok, tok_start_q,
                     cnt_sat(len_cur), 8'h00);
    unique case (mode_q)
      MODE_IDENT: begin
        flush_v = 1'b1;
        flush_r.ttype = word_type;
      end
      MODE_NUMBER: begin
        flush_v = 1'b1;
        flush_r.ttype = TT_NUMBER;
      end
      MODE_PEND: begin
        flush_v = 1'b1;
        flush_r.ttype = (pend_q == "=") ? TT_ASSIGN : TT_COMPARE;
        flush_r.len   = LEN_W'(1);
      end
      default: flush_v = 1'b0;
    endcase
  end

  // Classify a byte seen between tokens
  always_comb begin
    idle_v    = 1'b0;
    idle_mode = MODE_IDLE;
    idle_r    = mk_res(RK_TOKEN, TT_OP, line_q, col_cur, off_q,
                       COUNT_WIDTH'(1), 8'h00);
    priority if (is_space(char_i)) begin
      idle_mode = MODE_IDLE;
    end else if (is_alpha(char_i) || char_i == "_") begin
      idle_mode = MODE_IDENT;
    end else if (is_digit(char_i)) begin
      idle_mode = MODE_NUMBER;
    end else if (char_i == "\"") begin
      idle_mode = MODE_STRING;
    end else if (char_i == "=" || char_i == "!" || char_i == "<" || char_i == ">") begin
      idle_mode = MODE_PEND;
    end else begin
      idle_v = 1'b1;
      unique case (char_i)
        "+", "-", "*", "/": idle_r.ttype = TT_OP;
        "(":                idle_r.ttype = TT_LPAREN;
        ")":                idle_r.ttype = TT_RPAREN;
        "{":                idle_r.ttype = TT_LBRACE;
        "}":                idle_r.ttype = TT_RBRACE;
        ";":                idle_r.ttype = TT_SEMI;
        default: begin
          idle_r.kind  = RK_ILLEGAL;
          idle_r.ttype = TT_VAR;
          idle_r.bad   = char_i;
        end
      endcase
    end
  end

  // Main decision: results and next state
  always_comb begin
    mode_d       = mode_q;
    pend_d       = pend_q;
    line_d       = line_q;
    line_start_d = line_start_q;
    off_d        = off_inc(off_q);
    tok_start_d  = tok_start_q;
    tok_line_d   = tok_line_q;
    kw_d         = kw_q;
    take_idle    = 1'b0;
    a_v          = 1'b0;
    b_v          = 1'b0;
    a_r          = flush_r;
    b_r          = idle_r;

    if (eos) begin
      // Close what is open, then END, then back to reset values
      if (mode_q == MODE_STRING) begin
        a_v = 1'b1;
        a_r = mk_res(RK_UNTERM, TT_STRING, tok_line_q, col_tok, tok_start_q,
                     cnt_sat(len_cur), 8'h00);
      end else begin
        a_v = flush_v;
      end
      b_v          = 1'b1;
      b_r          = mk_res(RK_TOKEN, TT_END, line_q, '0, off_q, '0, 8'h00);
      mode_d       = MODE_IDLE;
      pend_d       = 8'h00;
      line_d       = COUNT_WIDTH'(1);
      line_start_d = '0;
      off_d        = '0;
      tok_start_d  = '0;
      tok_line_d   = '0;
      kw_d         = '0;
    end else begin
      unique case (mode_q)
        MODE_IDENT, MODE_NUMBER: begin
          if ((mode_q == MODE_IDENT) ? is_word(char_i) : is_digit(char_i)) begin
            kw_d = {kw_q[KW_W-9:0], char_i};
          end else begin
            a_v       = flush_v;
            take_idle = 1'b1;
          end
        end
        MODE_STRING: begin
          if (char_i == "\"") begin
            a_v    = 1'b1;
            a_r    = mk_res(RK_TOKEN, TT_STRING, tok_line_q, col_tok, tok_start_q,
                            cnt_sat(len_cur), 8'h00);
            mode_d = MODE_IDLE;
          end
        end
        MODE_PEND: begin
          if (char_i == "=") begin
            a_v    = 1'b1;
            a_r    = mk_res(RK_TOKEN, TT_COMPARE, tok_line_q, col_tok, tok_start_q,
                            COUNT_WIDTH'(2), 8'h00);
            mode_d = MODE_IDLE;
          end else begin
            a_v       = flush_v;
            take_idle = 1'b1;
          end
        end
        default: take_idle = 1'b1;
      endcase

      // Start whatever the byte begins
      if (take_idle) begin
        b_v         = idle_v;
        mode_d      = idle_mode;
        tok_start_d = (idle_mode == MODE_STRING) ? off_inc(off_q) : off_q;
        tok_line_d  = line_q;
        if (char_i == "\n") begin
          line_d       = (line_q == CNT_MAX) ? line_q : line_q + COUNT_WIDTH'(1);
          line_start_d = off_inc(off_q);
        end
        if (idle_mode == MODE_IDENT) kw_d = KW_W'(char_i);
        if (idle_mode == MODE_PEND) pend_d = char_i;
      end
    end
  end

  // Order the results: the closing one first
  always_comb begin
    out_o.r0    = a_v ? a_r : b_r;
    out_o.r1    = b_r;
    out_o.count = {1'b0, a_v} + {1'b0, b_v};
  end

  // Advance the state on each accepted word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= MODE_IDLE;
      pend_q       <= 8'h00;
      line_q       <= COUNT_WIDTH'(1);
      line_start_q <= '0;
      off_q        <= '0;
      tok_start_q  <= '0;
      tok_line_q   <= '0;
      kw_q         <= '0;
    end else if (accept_i) begin
      mode_q       <= mode_d;
      pend_q       <= pend_d;
      line_q       <= line_d;
      line_start_q <= line_start_d;
      off_q        <= off_d;
      tok_start_q  <= tok_start_d;
      tok_line_q   <= tok_line_d;
      kw_q         <= kw_d;
    end
  end

endmodule

>>> rtl/core/stl_out_buf.sv
// Two-entry result register that hands the results of one input word to the
// output stream in order. Depends on stl_pkg.
`timescale 1ns / 1ps

module stl_out_buf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  stl_pkg::lex_out_t res_i,
  output logic              in_ready_o,
  output logic              valid_o,
  input  logic              ready_i,
  output stl_pkg::res_t     data_o,
  output logic              last_o
);
  import stl_pkg::*;

  res_t       slot0_q, slot1_q;
  logic [1:0] cnt_q, cnt_d;
  logic       pop;

  assign valid_o    = (cnt_q != 2'd0);
  assign data_o     = slot0_q;
  assign last_o     = (cnt_q == 2'd1);
  assign pop        = valid_o && ready_i;
  assign in_ready_o = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && ready_i);

  // Fill count: load replaces, pop drains
  always_comb begin
    cnt_d = cnt_q;
    if (load_i && res_i.count != 2'd0) begin
      cnt_d = res_i.count;
    end else if (pop) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // Hold the payload; shift the second result forward on a pop
  always_ff @(posedge clk_i) begin
    if (load_i && res_i.count != 2'd0) begin
      slot0_q <= res_i.r0;
      slot1_q <= res_i.r1;
    end else if (pop && cnt_q == 2'd2) begin
      slot0_q <= slot1_q;
    end
  end

endmodule

>>> rtl/core/source_text_lexer.sv
// Top level of the source text lexer: byte stream in, token stream out.
// Depends on stl_pkg, stl_core and stl_out_buf.
//
// Usage:
//   Feed source bytes on the slave stream, one byte per word in tdata[7:0];
//   tlast high (or a zero byte) ends the source. The master stream carries one
//   result per word: tuser holds the result kind, tlast marks the last result
//   caused by one input word. Bytes that extend a token cause no result; a byte
//   causes at most two results, an end word one or two.
// Latency: a result appears on the master side the cycle after its byte is
//   accepted.
// Throughput: one byte per cycle while each byte causes at most one result;
//   a byte causing two results holds the input off while the two-entry result
//   register drains the first of them.
// Stall: while the receiver holds tready low, the result register keeps its
//   one or two results and the input stops as soon as any result is waiting,
//   also for bytes that would cause none.
// Reset: clears the lexer state to line 1, offset 0, and empties the result
//   register. After an END the lexer restarts at line 1, offset 0 as well.
`timescale 1ns / 1ps

module source_text_lexer #(
  parameter int OFFSET_WIDTH = 24,
  parameter int COUNT_WIDTH  = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // tdata: [7:0] char_byte
  input  logic [7:0]                       s_axis_tdata,
  // tlast: is_end
  input  logic                             s_axis_tlast,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // tdata: [4:0] token_type, [20:5] line_number, [36:21] column_number,
  //        [60:37] start_offset, [76:61] token_length, [84:77] bad_byte, rest 0
  output logic [stl_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  // tuser: [1:0] result_kind
  output logic [1:0]                       m_axis_tuser,
  // tlast: last_of_run
  output logic                             m_axis_tlast
);
  import stl_pkg::*;

  logic     accept;
  lex_out_t lex_res;
  res_t     head;

  assign accept = s_axis_tvalid && s_axis_tready;

  stl_core #(
    .OFFSET_WIDTH(OFFSET_WIDTH),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .accept_i(accept),
    .char_i  (s_axis_tdata),
    .end_i   (s_axis_tlast),
    .out_o   (lex_res)
  );

  stl_out_buf u_out_buf (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (accept),
    .res_i     (lex_res),
    .in_ready_o(s_axis_tready),
    .valid_o   (m_axis_tvalid),
    .ready_i   (m_axis_tready),
    .data_o    (head),
    .last_o    (m_axis_tlast)
  );

  // Pack the result word, token type lowest
  assign m_axis_tdata = OUT_DATA_W'({head.bad, head.len, head.start, head.col,
                                    head.line, head.ttype});
  assign m_axis_tuser = head.kind;

  // An end word always leaves at least the END result behind
  a_end_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tlast |=> m_axis_tvalid)
    else $error("end of source produced no result");

  // A result that is not the last of its run is followed by another
  a_run_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid)
    else $error("result run cut short");

  // An illegal-character error always covers exactly one byte
  a_illegal_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == RK_ILLEGAL) |-> (head.len == LEN_W'(1)))
    else $error("illegal character error with wrong length");

endmodule

>>> dv/tb_source_text_lexer.sv
`timescale 1ns / 1ps
// Self-checking testbench for source_text_lexer: streams directed and random
// source text, predicts every token and error word, checks them in order.
// Depends on stl_pkg and the source_text_lexer RTL.

module tb_source_text_lexer;
  import stl_pkg::*;

  localparam int ITEM_TARGET  = 480;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int DRAIN_CYCLES = 8;

  // One expected or observed result word, fields at the output widths
  typedef struct packed {
    logic [1:0]         kind;
    logic [TYPE_W-1:0]  ttype;
    logic [LINE_W-1:0]  line;
    logic [COL_W-1:0]   col;
    logic [START_W-1:0] start;
    logic [LEN_W-1:0]   len;
    logic [BYTE_W-1:0]  bad;
    logic               last;
  } lex_result_t;

  // Token predictor and in-order checker
  class token_scoreboard;
    lex_mode_e          mode;
    logic [7:0]         pend_char;
    logic [LINE_W-1:0]  line_cnt;
    logic [START_W-1:0] line_base;
    logic [START_W-1:0] offset;
    logic [START_W-1:0] tok_start;
    logic [LINE_W-1:0]  tok_line;
    logic [KW_W-1:0]    kw_tail;
    lex_result_t        token_q[$];
    lex_result_t        step_res[$];
    int                 mismatches;
    int                 bytes_in;
    int                 kind_seen[3];
    int                 type_seen[17];

    function new();
      mismatches = 0;
      bytes_in   = 0;
      foreach (kind_seen[i]) kind_seen[i] = 0;
      foreach (type_seen[i]) type_seen[i] = 0;
      restart();
    endfunction

    // Return to the start of a fresh source
    function void restart();
      mode      = MODE_IDLE;
      pend_char = '0;
      line_cnt  = LINE_W'(1);
      line_base = '0;
      offset    = '0;
      tok_start = '0;
      tok_line  = '0;
      kw_tail   = '0;
    endfunction

    function int pending();
      return token_q.size();
    endfunction

    function logic is_letter(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function logic is_numeral(logic [7:0] c);
      return c >= "0" && c <= "9";
    endfunction

    function logic is_name_char(logic [7:0] c);
      return is_letter(c) || is_numeral(c) || c == "_";
    endfunction

    function logic is_gap_char(logic [7:0] c);
      return c == " " || (c >= 8'd9 && c <= 8'd13);
    endfunction

    // Offsets stick at their maximum
    function logic [START_W-1:0] off_next(logic [START_W-1:0] v);
      return (&v) ? v : v + START_W'(1);
    endfunction

    // Distance a - b, floored at zero and held at the count maximum
    function logic [LEN_W-1:0] clip_count(logic [START_W-1:0] a, logic [START_W-1:0] b);
      logic [START_W-1:0] d;
      d = (a > b) ? a - b : '0;
      return (d > {LEN_W{1'b1}}) ? {LEN_W{1'b1}} : d[LEN_W-1:0];
    endfunction

    function void push(res_kind_e kind, tok_type_e ttype, logic [LINE_W-1:0] line,
                       logic [COL_W-1:0] col, logic [START_W-1:0] start,
                       logic [LEN_W-1:0] len, logic [BYTE_W-1:0] bad);
      lex_result_t r;
      r.kind  = kind;
      r.ttype = ttype;
      r.line  = line;
      r.col   = col;
      r.start = start;
      r.len   = len;
      r.bad   = bad;
      r.last  = 1'b0;
      step_res.push_back(r);
    endfunction

    function void push_token(tok_type_e ttype, logic [LEN_W-1:0] len);
      push(RK_TOKEN, ttype, tok_line, clip_count(tok_start, line_base), tok_start, len, '0);
    endfunction

    // Keywords match on length plus the trailing identifier bytes
    function tok_type_e word_type(logic [LEN_W-1:0] len);
      if (len == 3 && kw_tail == KW_VAR)    return TT_VAR;
      if (len == 5 && kw_tail == KW_PRINT)  return TT_PRINT;
      if (len == 2 && kw_tail == KW_IF)     return TT_IF;
      if (len == 4 && kw_tail == KW_ELSE)   return TT_ELSE;
      if (len == 6 && kw_tail == KW_RETURN) return TT_RETURN;
      return TT_IDENT;
    endfunction

    // Close whatever token is still open
    function void flush_open();
      logic [LEN_W-1:0] len;
      len = clip_count(offset, tok_start);
      case (mode)
        MODE_IDENT:  push_token(word_type(len), len);
        MODE_NUMBER: push_token(TT_NUMBER, len);
        MODE_PEND:   push_token((pend_char == "=") ? TT_ASSIGN : TT_COMPARE, LEN_W'(1));
        default: ;
      endcase
      mode = MODE_IDLE;
    endfunction

    // Handle a byte seen between tokens
    function void open_token(logic [7:0] c);
      mode      = MODE_IDLE;
      tok_start = offset;
      tok_line  = line_cnt;
      if (is_gap_char(c)) begin
        if (c == 8'h0A) begin
          line_cnt  = (&line_cnt) ? line_cnt : line_cnt + LINE_W'(1);
          line_base = off_next(offset);
        end
      end else if (is_letter(c) || c == "_") begin
        mode    = MODE_IDENT;
        kw_tail = '0;
        kw_tail[7:0] = c;
      end else if (is_numeral(c)) begin
        mode = MODE_NUMBER;
      end else if (c == "\"") begin
        mode      = MODE_STRING;
        tok_start = off_next(offset);
      end else if (c == "=" || c == "!" || c == "<" || c == ">") begin
        mode      = MODE_PEND;
        pend_char = c;
      end else begin
        case (c)
          "+", "-", "*", "/": push_token(TT_OP, LEN_W'(1));
          "(":     push_token(TT_LPAREN, LEN_W'(1));
          ")":     push_token(TT_RPAREN, LEN_W'(1));
          "{":     push_token(TT_LBRACE, LEN_W'(1));
          "}":     push_token(TT_RBRACE, LEN_W'(1));
          ";":     push_token(TT_SEMI, LEN_W'(1));
          default: push(RK_ILLEGAL, TT_VAR, line_cnt, clip_count(offset, line_base),
                        offset, LEN_W'(1), c);
        endcase
      end
    endfunction

    // Predict the results of one accepted input word
    function void note_input(logic [7:0] c, logic e);
      step_res.delete();
      bytes_in++;
      if (e || c == 8'h00) begin
        if (mode == MODE_STRING) begin
          push(RK_UNTERM, TT_STRING, tok_line, clip_count(tok_start, line_base),
               tok_start, clip_count(offset, tok_start), '0);
          mode = MODE_IDLE;
        end else begin
          flush_open();
        end
        push(RK_TOKEN, TT_END, line_cnt, '0, offset, '0, '0);
        restart();
      end else begin
        case (mode)
          MODE_IDENT, MODE_NUMBER: begin
            if ((mode == MODE_IDENT) ? is_name_char(c) : is_numeral(c)) begin
              kw_tail = {kw_tail[KW_W-9:0], c};
            end else begin
              flush_open();
              open_token(c);
            end
          end
          MODE_STRING: begin
            if (c == "\"") begin
              push_token(TT_STRING, clip_count(offset, tok_start));
              mode = MODE_IDLE;
            end
          end
          MODE_PEND: begin
            if (c == "=") begin
              push_token(TT_COMPARE, LEN_W'(2));
              mode = MODE_IDLE;
            end else begin
              flush_open();
              open_token(c);
            end
          end
          default: open_token(c);
        endcase
        offset = off_next(offset);
      end
      if (step_res.size() > 0) step_res[step_res.size()-1].last = 1'b1;
      foreach (step_res[i]) token_q.push_back(step_res[i]);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s mismatch: expected %0d, got %0d", name, want, got);
        mismatches++;
      end
    endfunction

    // Check one accepted result word against the oldest prediction
    function void check_result(lex_result_t got);
      lex_result_t want;
      if (token_q.size() == 0) begin
        $error("unexpected result word: kind %0d type %0d start %0d",
               got.kind, got.ttype, got.start);
        mismatches++;
        return;
      end
      want = token_q.pop_front();
      compare_field("result_kind", 32'(want.kind), 32'(got.kind));
      compare_field("token_type", 32'(want.ttype), 32'(got.ttype));
      compare_field("line_number", 32'(want.line), 32'(got.line));
      compare_field("column_number", 32'(want.col), 32'(got.col));
      compare_field("start_offset", 32'(want.start), 32'(got.start));
      compare_field("token_length", 32'(want.len), 32'(got.len));
      compare_field("bad_byte", 32'(want.bad), 32'(got.bad));
      compare_field("last_of_run", 32'(want.last), 32'(got.last));
      kind_seen[want.kind]++;
      if (want.kind == RK_TOKEN) type_seen[want.ttype]++;
    endfunction
  endclass

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [7:0]            s_axis_tdata  = '0;
  logic                  s_axis_tlast  = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [1:0]            m_axis_tuser;
  logic                  m_axis_tlast;

  token_scoreboard lex_board = new();
  bit              steady_flow = 1'b0;
  int              items_sent = 0;
  int              cycle_count = 0;
  string           kw_names[5] = '{"var", "print", "if", "else", "return"};

  source_text_lexer DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Stop a hung run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Idle lengths: mostly none, some short, a few long
  function automatic int pick_gap();
    int roll;
    if (steady_flow) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 70) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  function automatic logic [7:0] word_char();
    int r;
    r = $urandom_range(0, 62);
    if (r < 26) return 8'("a" + r);
    if (r < 52) return 8'("A" + r - 26);
    if (r < 62) return 8'("0" + r - 52);
    return "_";
  endfunction

  function automatic logic [7:0] illegal_char();
    string punct;
    punct = "@#$%&~`'[]|:,.?^\\";
    case ($urandom_range(0, 2))
      0:       return 8'($urandom_range(128, 255));
      1:       return ($urandom_range(0, 1) == 0) ? 8'($urandom_range(1, 8))
                                                  : 8'($urandom_range(14, 31));
      default: return punct[$urandom_range(0, punct.len() - 1)];
    endcase
  endfunction

  // Drive one input word and hold it until accepted
  task automatic send_word(input logic [7:0] b, input logic e);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= e;
    do @(posedge clk_i); while (!s_axis_tready);
    lex_board.note_input(b, e);
    items_sent++;
  endtask

  task automatic send_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) send_word(s[i], 1'b0);
  endtask

  // Hold the sender until every predicted result has been seen
  task automatic drain_wait();
    s_axis_tvalid <= 1'b0;
    while (lex_board.pending() != 0) @(posedge clk_i);
  endtask

  // Send one well-formed lexeme with random content, or noise, sometimes ending the source
  task automatic send_fragment();
    logic [7:0] text[$];
    logic [7:0] blanks[6];
    logic [7:0] c;
    string      word;
    int         roll, n, i;
    bit         open_end;
    blanks   = '{" ", 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};
    open_end = 1'b0;
    roll     = $urandom_range(0, 99);
    if (roll < 12) begin
      // keyword, sometimes grown into a plain identifier
      word = kw_names[$urandom_range(0, 4)];
      for (i = 0; i < word.len(); i++) text.push_back(word[i]);
      if ($urandom_range(0, 3) == 0) text.push_back(word_char());
    end else if (roll < 24) begin
      do c = word_char(); while (c >= "0" && c <= "9");
      text.push_back(c);
      n = $urandom_range(0, 8);
      repeat (n) text.push_back(word_char());
    end else if (roll < 34) begin
      n = $urandom_range(1, 5);
      repeat (n) text.push_back(8'("0" + $urandom_range(0, 9)));
    end else if (roll < 44) begin
      // quoted string, newlines and high bytes allowed inside
      text.push_back("\"");
      n = $urandom_range(0, 6);
      repeat (n) begin
        case ($urandom_range(0, 4))
          0:       c = 8'h0A;
          1:       c = 8'($urandom_range(1, 255));
          default: c = 8'($urandom_range(8'h20, 8'h7E));
        endcase
        if (c == "\"") c = "a";
        text.push_back(c);
      end
      if ($urandom_range(0, 7) == 0) open_end = 1'b1;
      else text.push_back("\"");
    end else if (roll < 56) begin
      word = "+-*/(){};";
      text.push_back(word[$urandom_range(0, word.len() - 1)]);
    end else if (roll < 68) begin
      word = "=!<>";
      text.push_back(word[$urandom_range(0, 3)]);
      if ($urandom_range(0, 1) == 0) text.push_back("=");
    end else if (roll < 84) begin
      n = $urandom_range(1, 3);
      repeat (n) text.push_back(blanks[$urandom_range(0, 5)]);
    end else if (roll < 90) begin
      text.push_back(illegal_char());
    end else if (roll < 96) begin
      text.push_back(8'($urandom_range(0, 255)));
    end else begin
      open_end = 1'b1;
    end
    foreach (text[k]) send_word(text[k], 1'b0);
    // close the source by end flag or by a zero byte
    if (open_end) begin
      if ($urandom_range(0, 2) == 0) send_word(8'h00, 1'b0);
      else send_word(8'($urandom_range(0, 255)), 1'b1);
    end
  endtask

  // Accept and check result words, stalling at random
  initial begin
    int          stall_left;
    lex_result_t got;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) begin
        got.kind  = m_axis_tuser;
        got.ttype = m_axis_tdata[4:0];
        got.line  = m_axis_tdata[20:5];
        got.col   = m_axis_tdata[36:21];
        got.start = m_axis_tdata[60:37];
        got.len   = m_axis_tdata[76:61];
        got.bad   = m_axis_tdata[84:77];
        got.last  = m_axis_tlast;
        lex_board.check_result(got);
      end
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        stall_left = pick_gap();
      end
    end
  end

  // Main sequence
  initial begin
    int base;
    bit drained_mid;
    drained_mid = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // lone and paired compare/assign, brackets, newline inside a string,
    // illegal and high bytes, end flushing a pending compare, open string
    send_text("x=!=<>=;(+)\"a\n\"\n@");
    send_word(8'hFF, 1'b0);
    send_word(8'h80, 1'b0);
    send_text("9!");
    send_word(8'h00, 1'b1);
    send_text("\"q");
    send_word(8'h00, 1'b0);
    drain_wait();

    // random source text, with a no-idle stretch and a mid-run drain
    base = items_sent;
    while (items_sent - base < ITEM_TARGET) begin
      steady_flow = (items_sent - base >= 150) && (items_sent - base < 230);
      if (!drained_mid && items_sent - base >= 300) begin
        drain_wait();
        drained_mid = 1'b1;
      end
      send_fragment();
    end
    steady_flow = 1'b0;
    send_word(8'($urandom_range(0, 255)), 1'b1);
    s_axis_tvalid <= 1'b0;

    while (lex_board.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Lexed %0d source bytes into %0d tokens, %0d illegal-byte and %0d open-string errors.",
             lex_board.bytes_in, lex_board.kind_seen[RK_TOKEN],
             lex_board.kind_seen[RK_ILLEGAL], lex_board.kind_seen[RK_UNTERM]);
    $display("Seen: %0d keywords, %0d strings, %0d compares, %0d assigns, %0d END marks.",
             lex_board.type_seen[TT_VAR] + lex_board.type_seen[TT_PRINT] +
             lex_board.type_seen[TT_IF] + lex_board.type_seen[TT_ELSE] +
             lex_board.type_seen[TT_RETURN], lex_board.type_seen[TT_STRING],
             lex_board.type_seen[TT_COMPARE], lex_board.type_seen[TT_ASSIGN],
             lex_board.type_seen[TT_END]);
    if (lex_board.mismatches == 0 && lex_board.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
